// ----- rtl/rcfg_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfg_pkg
// Shared types and constants for the radio command frame gate.
// ----------------------------------------------------------------------------
package rcfg_pkg;

  localparam int RX_W      = 8;
  localparam int TIME_W    = 32;
  localparam int STATE_W   = 3;
  localparam int ALT_W     = 18;
  localparam int VS_W      = 15;
  localparam int TMO_W     = 16;
  localparam int RESP_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 18;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  localparam int HEAD_DEPTH = 5;
  localparam int HEAD_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AIRBORNE_ALT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLING_SPEED = 2'd2;

  localparam logic [TMO_W-1:0]        TIMEOUT_RESET = 16'd200;
  localparam logic signed [ALT_W-1:0] ALT_RESET     = 18'sd2000;
  localparam logic signed [VS_W-1:0]  FALL_RESET    = -15'sd200;

  // flight states
  localparam logic [STATE_W-1:0] FS_IDLE    = 3'd0;
  localparam logic [STATE_W-1:0] FS_ASCENT  = 3'd1;
  localparam logic [STATE_W-1:0] FS_FAST    = 3'd2;
  localparam logic [STATE_W-1:0] FS_SLOW    = 3'd3;
  localparam logic [STATE_W-1:0] FS_LANDED  = 3'd4;

  // ASCII
  localparam logic [RX_W-1:0] CH_OPEN  = 8'h3C; // '<'
  localparam logic [RX_W-1:0] CH_CLOSE = 8'h3E; // '>'
  localparam logic [RX_W-1:0] CH_C     = 8'h43;
  localparam logic [RX_W-1:0] CH_M     = 8'h4D;
  localparam logic [RX_W-1:0] CH_D     = 8'h44;
  localparam logic [RX_W-1:0] CH_COLON = 8'h3A;
  localparam logic [RX_W-1:0] CH_R     = 8'h52;
  localparam logic [RX_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [RX_W-1:0] CH_ONE   = 8'h31;
  localparam logic [RX_W-1:0] CH_S     = 8'h53;
  localparam logic [RX_W-1:0] CH_O     = 8'h4F;
  localparam logic [RX_W-1:0] CH_I     = 8'h49;
  localparam logic [RX_W-1:0] CH_A     = 8'h41;
  localparam logic [RX_W-1:0] CH_L     = 8'h4C;

  // response codes
  localparam logic [RESP_W-1:0] RSP_RESET        = 5'd0;
  localparam logic [RESP_W-1:0] RSP_BARO_CAL     = 5'd1;
  localparam logic [RESP_W-1:0] RSP_IMU_CAL      = 5'd2;
  localparam logic [RESP_W-1:0] RSP_CLOSED       = 5'd3;
  localparam logic [RESP_W-1:0] RSP_ALREADY_OPEN = 5'd4;
  localparam logic [RESP_W-1:0] RSP_TEST_OPEN    = 5'd5;
  localparam logic [RESP_W-1:0] RSP_EMERGENCY    = 5'd6;
  localparam logic [RESP_W-1:0] RSP_DEPLOY_DENY  = 5'd7;
  localparam logic [RESP_W-1:0] RSP_AUTO         = 5'd8;
  localparam logic [RESP_W-1:0] RSP_IDLE         = 5'd9;
  localparam logic [RESP_W-1:0] RSP_LANDED       = 5'd10;
  localparam logic [RESP_W-1:0] RSP_ASCENT       = 5'd11;
  localparam logic [RESP_W-1:0] RSP_ASCENT_DENY  = 5'd12;
  localparam logic [RESP_W-1:0] RSP_FLIGHT_DENY  = 5'd13;
  localparam logic [RESP_W-1:0] RSP_UNKNOWN      = 5'd14;
  localparam logic [RESP_W-1:0] RSP_BAD_SIG      = 5'd15;
  localparam logic [RESP_W-1:0] RSP_TOO_LONG     = 5'd16;

  typedef enum logic [1:0] {
    EVT_NONE,
    EVT_CMD,
    EVT_BAD_SIG,
    EVT_TOO_LONG
  } frame_evt_kind_t;

  typedef struct packed {
    frame_evt_kind_t kind;
    logic [RX_W-1:0] letter;
  } frame_evt_t;

  typedef struct packed {
    logic               emit;
    logic [RESP_W-1:0]  response;
    logic               set_state;
    logic [STATE_W-1:0] next_state;
    logic               open_chute;
    logic               close_chute;
    logic               calibrate_baro;
    logic               calibrate_imu;
    logic               reset_detectors;
    logic               clear_override;
    logic               wipe_mission;
  } cmd_result_t;

endpackage

// ----- rtl/rcfg_frame.sv -----
// ----------------------------------------------------------------------------
// rcfg_frame
// Frame tracker: timeout, '<' restart, payload head capture and overflow.
// ----------------------------------------------------------------------------
module rcfg_frame #(
  parameter int MAX_PAYLOAD = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [rcfg_pkg::RX_W-1:0]     rx_byte,
  input  logic [rcfg_pkg::TIME_W-1:0]   now_ms,
  input  logic [rcfg_pkg::TMO_W-1:0]    frame_timeout_ms,
  output rcfg_pkg::frame_evt_t          evt
);
  import rcfg_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic              frame_open;
  logic              frame_open_next;
  logic [CW-1:0]     payload_count;
  logic [CW-1:0]     payload_count_next;
  logic [TIME_W-1:0] frame_start_ms;
  logic [RX_W-1:0]   payload_head [HEAD_DEPTH];

  logic [TIME_W-1:0] age;
  logic              open_eff;
  logic              sig_ok;
  logic              head_we;

  assign age      = now_ms - frame_start_ms;
  assign open_eff = frame_open && !(age > TIME_W'(frame_timeout_ms));
  assign sig_ok   = (payload_count == CW'(HEAD_DEPTH)) && (payload_head[0] == CH_C) &&
                    (payload_head[1] == CH_M) && (payload_head[2] == CH_D) &&
                    (payload_head[3] == CH_COLON);

  always_comb begin
    frame_open_next    = open_eff;
    payload_count_next = payload_count;
    head_we            = 1'b0;
    evt.kind           = EVT_NONE;
    evt.letter         = payload_head[HEAD_DEPTH-1];
    if (rx_byte == CH_OPEN) begin
      frame_open_next    = 1'b1;
      payload_count_next = '0;
    end else if (open_eff && rx_byte == CH_CLOSE) begin
      frame_open_next    = 1'b0;
      payload_count_next = '0;
      evt.kind           = sig_ok ? EVT_CMD : EVT_BAD_SIG;
    end else if (open_eff) begin
      if (payload_count < CW'(MAX_PAYLOAD)) begin
        head_we            = payload_count < CW'(HEAD_DEPTH);
        payload_count_next = payload_count + CW'(1);
      end else begin
        frame_open_next    = 1'b0;
        payload_count_next = '0;
        evt.kind           = EVT_TOO_LONG;
      end
    end else begin
      payload_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      payload_count  <= '0;
      frame_start_ms <= '0;
    end else if (fire) begin
      frame_open    <= frame_open_next;
      payload_count <= payload_count_next;
      if (rx_byte == CH_OPEN) begin
        frame_start_ms <= now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && head_we) begin
      payload_head[payload_count[HEAD_IDX_W-1:0]] <= rx_byte;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    payload_count <= CW'(MAX_PAYLOAD))
    else $error("payload count beyond limit");
  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> payload_count == '0)
    else $error("closed frame holds payload");
  a_close_event: assert property (@(posedge clk) disable iff (rst)
    fire && evt.kind != EVT_NONE |=> !frame_open)
    else $error("frame still open after result");
`endif

endmodule

// ----- rtl/rcfg_decode.sv -----
// ----------------------------------------------------------------------------
// rcfg_decode
// Command letter decoder with flight context gating.
// ----------------------------------------------------------------------------
module rcfg_decode (
  input  rcfg_pkg::frame_evt_t                 evt,
  input  logic [rcfg_pkg::STATE_W-1:0]         flight_state,
  input  logic                                 chute_deployed,
  input  logic                                 baro_ok,
  input  logic signed [rcfg_pkg::ALT_W-1:0]    altitude_cm,
  input  logic signed [rcfg_pkg::VS_W-1:0]     vertical_speed_cm_s,
  input  logic signed [rcfg_pkg::ALT_W-1:0]    airborne_altitude_cm,
  input  logic signed [rcfg_pkg::VS_W-1:0]     falling_speed_cm_s,
  output rcfg_pkg::cmd_result_t                res
);
  import rcfg_pkg::*;

  logic ground;
  logic airborne;

  assign ground   = (flight_state == FS_IDLE) || (flight_state == FS_LANDED);
  assign airborne = baro_ok && ((altitude_cm > airborne_altitude_cm) ||
                                (vertical_speed_cm_s < falling_speed_cm_s));

  always_comb begin
    res      = '0;
    res.emit = 1'b1;
    unique case (evt.kind)
      EVT_NONE:     res.emit = 1'b0;
      EVT_BAD_SIG:  res.response = RSP_BAD_SIG;
      EVT_TOO_LONG: res.response = RSP_TOO_LONG;
      EVT_CMD: begin
        case (evt.letter) inside
          CH_R: begin
            if (ground) begin
              res.response        = RSP_RESET;
              res.set_state       = 1'b1;
              res.next_state      = FS_IDLE;
              res.calibrate_baro  = baro_ok;
              res.calibrate_imu   = 1'b1;
              res.reset_detectors = 1'b1;
              res.clear_override  = 1'b1;
              res.wipe_mission    = 1'b1;
            end else begin
              res.response = RSP_FLIGHT_DENY;
            end
          end
          CH_C: begin
            if (ground && baro_ok) begin
              res.response        = RSP_BARO_CAL;
              res.calibrate_baro  = 1'b1;
              res.reset_detectors = 1'b1;
            end else if (ground) begin
              res.emit = 1'b0;
            end else begin
              res.response = RSP_FLIGHT_DENY;
            end
          end
          CH_M: begin
            if (ground) begin
              res.response      = RSP_IMU_CAL;
              res.calibrate_imu = 1'b1;
            end else begin
              res.response = RSP_FLIGHT_DENY;
            end
          end
          CH_ZERO: begin
            if (ground) begin
              res.response    = RSP_CLOSED;
              res.close_chute = 1'b1;
            end else begin
              res.response = RSP_FLIGHT_DENY;
            end
          end
          CH_ONE, CH_S: begin
            if (chute_deployed) begin
              res.response = RSP_ALREADY_OPEN;
            end else if (ground && !airborne) begin
              res.response   = RSP_TEST_OPEN;
              res.open_chute = 1'b1;
            end else if (flight_state != FS_ASCENT && flight_state != FS_FAST &&
                         flight_state != FS_IDLE) begin
              res.response = RSP_DEPLOY_DENY;
            end else begin
              res.response        = RSP_EMERGENCY;
              res.set_state       = 1'b1;
              res.next_state      = FS_SLOW;
              res.reset_detectors = 1'b1;
              res.clear_override  = 1'b1;
            end
          end
          CH_O: begin
            res.response        = RSP_AUTO;
            res.reset_detectors = 1'b1;
            res.clear_override  = 1'b1;
          end
          CH_I: begin
            if (ground) begin
              res.response        = RSP_IDLE;
              res.set_state       = 1'b1;
              res.next_state      = FS_IDLE;
              res.reset_detectors = 1'b1;
              res.clear_override  = 1'b1;
            end else begin
              res.response = RSP_FLIGHT_DENY;
            end
          end
          CH_A: begin
            if (flight_state != FS_IDLE) begin
              res.response = RSP_ASCENT_DENY;
            end else begin
              res.response        = RSP_ASCENT;
              res.set_state       = 1'b1;
              res.next_state      = FS_ASCENT;
              res.reset_detectors = 1'b1;
              res.clear_override  = 1'b1;
            end
          end
          CH_L: begin
            if (ground) begin
              res.response        = RSP_LANDED;
              res.set_state       = 1'b1;
              res.next_state      = FS_LANDED;
              res.reset_detectors = 1'b1;
              res.clear_override  = 1'b1;
            end else begin
              res.response = RSP_FLIGHT_DENY;
            end
          end
          default: res.response = RSP_UNKNOWN;
        endcase
      end
      default: res.emit = 1'b0;
    endcase
  end

endmodule

// ----- rtl/radio_command_frame_gate.sv -----
// ----------------------------------------------------------------------------
// radio_command_frame_gate
// Frames '<'...'>' radio packets and decodes "CMD:x" into responses and
// action strobes, gated by the flight context carried with each byte.
// ----------------------------------------------------------------------------
//  channel | direction | beat
//  s_axis  | in        | one received byte with timestamp and flight context
//  m_axis  | out       | zero or one command result per input byte
//  cfg     | in        | register write: timeout, airborne altitude, fall speed
//
// One byte per cycle while the result register is not stalled; a result passes
// from its byte beat through the input register and then the result register.
// Reset closes any open frame and restores the register defaults.
// A stalled result holds the result register; the input register keeps taking
// a byte while it is empty or the result register is free or being drained.
module radio_command_frame_gate #(
  parameter int MAX_PAYLOAD = 14
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // rx_byte[7:0], now_ms[39:8], flight_state[42:40], chute_deployed[43],
  // baro_ok[44], altitude_cm[62:45], vertical_speed_cm_s[77:63], zero[79:78]
  input  logic [rcfg_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // response[4:0], set_state[5], next_state[8:6], open_chute[9],
  // close_chute[10], calibrate_baro[11], calibrate_imu[12],
  // reset_detectors[13], clear_override[14], wipe_mission[15]
  output logic [rcfg_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [rcfg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcfg_pkg::CFG_DAT_W-1:0]     cfg_data
);
  import rcfg_pkg::*;

  logic [TMO_W-1:0]        frame_timeout_ms;
  logic signed [ALT_W-1:0] airborne_altitude_cm;
  logic signed [VS_W-1:0]  falling_speed_cm_s;

  logic                 in_valid;
  logic [IN_DATA_W-1:0] in_data;
  logic                 advance;
  logic                 fire;
  frame_evt_t           evt;
  cmd_result_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_timeout_ms     <= TIMEOUT_RESET;
      airborne_altitude_cm <= ALT_RESET;
      falling_speed_cm_s   <= FALL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_TIMEOUT: frame_timeout_ms     <= cfg_data[TMO_W-1:0];
        CFG_AIRBORNE_ALT:  airborne_altitude_cm <= cfg_data[ALT_W-1:0];
        CFG_FALLING_SPEED: falling_speed_cm_s   <= cfg_data[VS_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data <= s_axis_tdata;
    end
  end

  rcfg_frame #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_frame (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .rx_byte          (in_data[7:0]),
    .now_ms           (in_data[39:8]),
    .frame_timeout_ms (frame_timeout_ms),
    .evt              (evt)
  );

  rcfg_decode u_decode (
    .evt                  (evt),
    .flight_state         (in_data[42:40]),
    .chute_deployed       (in_data[43]),
    .baro_ok              (in_data[44]),
    .altitude_cm          (in_data[62:45]),
    .vertical_speed_cm_s  (in_data[77:63]),
    .airborne_altitude_cm (airborne_altitude_cm),
    .falling_speed_cm_s   (falling_speed_cm_s),
    .res                  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {res.wipe_mission, res.clear_override, res.reset_detectors,
                       res.calibrate_imu, res.calibrate_baro, res.close_chute,
                       res.open_chute, res.next_state, res.set_state, res.response};
    end
  end

`ifndef NO_ASSERTIONS
  a_state_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[5] |-> m_axis_tdata[8:6] == FS_IDLE)
    else $error("next state without set");
  a_chute_excl: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
    else $error("open and close chute together");
  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[4:0] == RSP_BAD_SIG ||
                      m_axis_tdata[4:0] == RSP_TOO_LONG) |-> m_axis_tdata[15:5] == '0)
    else $error("strobes on error response");
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    advance && !fire |=> !m_axis_tvalid)
    else $error("result without byte");
`endif

endmodule
